@@ hdl/nea_pkg.sv @@
// shared types and constants of the navigation ephemeris assembler
`default_nettype none
package nea_pkg;

    localparam int          ChannelsDefault = 12;
    localparam int          SfKept          = 3;
    localparam int          SfWords         = 10;
    localparam int          ChWords         = SfKept * SfWords;
    localparam int          RunLen          = 26;
    localparam logic [4:0]  CodeDropped     = 5'd26;
    localparam logic [4:0]  CodeLastRun     = 5'd25;
    localparam logic [4:0]  UraLimitReset   = 5'd8;
    localparam logic [0:0]  CmdWord         = 1'b0;
    localparam logic [0:0]  CmdClear        = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;     // input beat taken
        logic load;       // sweep channel words from the store
        logic chk_clear;  // failed check, drop channel
        logic commit;     // accept new issue, start a run
        logic out_item;   // load next run beat into output register
        logic out_drop;   // load dropped status beat
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic drop_emit;   // clear of a channel holding a valid ephemeris
        logic run_start;   // commit completes all three subframes
        logic load_done;   // last channel word captured
        logic chk_fail;    // ura or health check failed
        logic chk_emit;    // consistent and new issue
        logic lat_valid;   // latched channel holds a valid ephemeris
        logic emit_last;   // next run beat is the final one
        logic out_free;    // output register can take a beat
    } t_sts;

endpackage
`default_nettype wire

@@ hdl/nea_ctrl.sv @@
// controller state machine of the navigation ephemeris assembler
`default_nettype none
module nea_ctrl
    import nea_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    input  wire t_sts i_sts,
    output logic      o_stall,
    output t_cmd      o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_CHECK = 6'b000100,
        S_EMIT  = 6'b001000,
        S_DROP  = 6'b010000,
        S_FLUSH = 6'b100000
    } t_state;

    t_state r_state, n_state;

    assign o_stall = (r_state != S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.drop_emit) begin
                        n_state = S_DROP;
                    end else if (i_sts.run_start) begin
                        n_state = S_LOAD;
                    end
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_sts.load_done) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_sts.chk_fail) begin
                    o_cmd.chk_clear = 1'b1;
                    n_state = i_sts.lat_valid ? S_DROP : S_IDLE;
                end else if (i_sts.chk_emit) begin
                    o_cmd.commit = 1'b1;
                    n_state = S_EMIT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_item = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = S_FLUSH;
                    end
                end
            end
            S_DROP: begin
                if (i_sts.out_free) begin
                    o_cmd.out_drop = 1'b1;
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

@@ hdl/nea_dp.sv @@
// datapath: word store, per-channel state, field extraction and output register
`default_nettype none
module nea_dp
    import nea_pkg::*;
#(
    parameter int CHANNELS = ChannelsDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_cmd               i_cmd,
    output t_sts                    o_sts,
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_wdata,
    input  wire logic [0:0]         i_command,
    input  wire logic [3:0]         i_channel,
    input  wire logic [2:0]         i_subframe,
    input  wire logic [3:0]         i_word_index,
    input  wire logic [23:0]        i_nav_word,
    input  wire logic [5:0]         i_sat_prn,
    input  wire logic               i_stall,
    output logic                    o_valid,
    output logic [3:0]              o_out_channel,
    output logic [5:0]              o_out_prn,
    output logic [4:0]              o_item_code,
    output logic signed [32:0]      o_item_value,
    output logic                    o_last_item
);

    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int DEPTH = CHANNELS * ChWords;
    localparam int AW    = $clog2(DEPTH);

    logic [23:0]     r_mem [DEPTH];
    logic [2:0]      r_held  [CHANNELS];
    logic            r_evld  [CHANNELS];
    logic [7:0]      r_iode  [CHANNELS];
    logic [4:0]      r_max;
    logic [CH_W-1:0] r_ch;
    logic [5:0]      r_prn;
    logic [4:0]      r_cnt;
    logic            r_rd_v;
    logic [4:0]      r_rd_idx;
    logic [23:0]     r_rd;
    logic [23:0]     r_w [ChWords];
    logic [4:0]      r_eidx;
    logic            r_ovld;

    logic [CH_W-1:0] in_ch;
    logic            in_ok, sf_ok, store_en, commit_en, read_en;
    logic [2:0]      sf_bit, held_new;
    logic [AW-1:0]   wr_addr, rd_addr;
    logic [3:0]      ura;
    logic [7:0]      iode2;
    logic            consistent, fresh;
    logic signed [32:0] item;

    assign in_ch     = i_channel[CH_W-1:0];
    assign in_ok     = ({1'b0, i_channel} < 5'(CHANNELS));
    assign sf_ok     = (i_subframe >= 3'd1) && (i_subframe <= 3'(SfKept))
                       && (i_word_index < 4'(SfWords));
    assign store_en  = i_cmd.accept && in_ok && (i_command == CmdWord) && sf_ok;
    assign commit_en = store_en && (i_word_index == 4'(SfWords - 1));
    assign sf_bit    = 3'(1) << (i_subframe - 3'd1);
    assign held_new  = r_held[in_ch] | sf_bit;
    assign wr_addr   = AW'(in_ch) * AW'(ChWords)
                     + AW'(i_subframe - 3'd1) * AW'(SfWords) + AW'(i_word_index);
    assign read_en   = i_cmd.load && (r_cnt < 5'(ChWords));
    assign rd_addr   = AW'(r_ch) * AW'(ChWords) + AW'(r_cnt);

    // check fields: subframe 1 word 3, word 8, subframe 2 word 3, subframe 3 word 10
    assign ura        = r_w[2][11:8];
    assign iode2      = r_w[12][23:16];
    assign consistent = (r_w[7][23:16] == iode2) && (iode2 == r_w[29][23:16]);
    assign fresh      = !(r_evld[r_ch] && (r_iode[r_ch] == iode2));

    always_comb begin
        o_sts           = '0;
        o_sts.drop_emit = i_cmd.accept && in_ok && (i_command == CmdClear) && r_evld[in_ch];
        o_sts.run_start = commit_en && (held_new == 3'b111);
        o_sts.load_done = r_rd_v && (r_rd_idx == 5'(ChWords - 1));
        o_sts.chk_fail  = ({1'b0, ura} >= r_max) || r_w[2][7];
        o_sts.chk_emit  = consistent && fresh;
        o_sts.lat_valid = r_evld[r_ch];
        o_sts.emit_last = (r_eidx == CodeLastRun);
        o_sts.out_free  = !r_ovld || !i_stall;
    end

    always_comb begin
        case (r_eidx)
            5'd0:  item = 33'(r_w[2][23:14]);
            5'd1:  item = 33'(r_w[2][11:8]);
            5'd2:  item = 33'(r_w[2][7:2]);
            5'd3:  item = 33'({r_w[2][1:0], r_w[7][23:16]});
            5'd4:  item = 33'(r_w[12][23:16]);
            5'd5:  item = 33'(r_w[7][15:0]);
            5'd6:  item = {{25{r_w[6][7]}}, r_w[6][7:0]};
            5'd7:  item = {{25{r_w[8][23]}}, r_w[8][23:16]};
            5'd8:  item = {{17{r_w[8][15]}}, r_w[8][15:0]};
            5'd9:  item = {{11{r_w[9][23]}}, r_w[9][23:2]};
            5'd10: item = {{17{r_w[12][15]}}, r_w[12][15:0]};
            5'd11: item = {{17{r_w[13][23]}}, r_w[13][23:8]};
            5'd12: item = {r_w[13][7], r_w[13][7:0], r_w[14]};
            5'd13: item = {{17{r_w[15][23]}}, r_w[15][23:8]};
            5'd14: item = {1'b0, r_w[15][7:0], r_w[16]};
            5'd15: item = {{17{r_w[17][23]}}, r_w[17][23:8]};
            5'd16: item = {1'b0, r_w[17][7:0], r_w[18]};
            5'd17: item = 33'(r_w[19][23:8]);
            5'd18: item = {{17{r_w[22][23]}}, r_w[22][23:8]};
            5'd19: item = {r_w[22][7], r_w[22][7:0], r_w[23]};
            5'd20: item = {{17{r_w[24][23]}}, r_w[24][23:8]};
            5'd21: item = {r_w[24][7], r_w[24][7:0], r_w[25]};
            5'd22: item = {{17{r_w[26][23]}}, r_w[26][23:8]};
            5'd23: item = {r_w[26][7], r_w[26][7:0], r_w[27]};
            5'd24: item = {{9{r_w[28][23]}}, r_w[28]};
            5'd25: item = {{19{r_w[29][15]}}, r_w[29][15:2]};
            default: item = '0;
        endcase
    end

    // word store, sweep capture and output register
    always_ff @(posedge i_clk) begin
        if (store_en) begin
            r_mem[wr_addr] <= i_nav_word;
        end
        if (read_en) begin
            r_rd <= r_mem[rd_addr];
        end
        r_rd_idx <= r_cnt;
        if (r_rd_v) begin
            r_w[r_rd_idx] <= r_rd;
        end
        if (i_cmd.accept) begin
            r_ch  <= in_ch;
            r_prn <= i_sat_prn;
        end
        if (i_cmd.out_item) begin
            o_out_channel <= 4'(r_ch);
            o_out_prn     <= r_prn;
            o_item_code   <= r_eidx;
            o_item_value  <= item;
            o_last_item   <= (r_eidx == CodeLastRun);
        end else if (i_cmd.out_drop) begin
            o_out_channel <= 4'(r_ch);
            o_out_prn     <= r_prn;
            o_item_code   <= CodeDropped;
            o_item_value  <= '0;
            o_last_item   <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max  <= UraLimitReset;
            r_cnt  <= '0;
            r_rd_v <= 1'b0;
            r_eidx <= '0;
            r_ovld <= 1'b0;
            for (int c = 0; c < CHANNELS; c++) begin
                r_held[c] <= '0;
                r_evld[c] <= 1'b0;
                r_iode[c] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_max <= i_cfg_wdata;
            end
            r_rd_v <= read_en;
            if (i_cmd.accept) begin
                r_cnt <= '0;
            end else if (read_en) begin
                r_cnt <= r_cnt + 5'd1;
            end
            if (i_cmd.accept && in_ok && (i_command == CmdClear)) begin
                r_held[in_ch] <= '0;
                r_evld[in_ch] <= 1'b0;
            end else if (commit_en) begin
                r_held[in_ch] <= held_new;
            end
            if (i_cmd.chk_clear) begin
                r_held[r_ch] <= '0;
                r_evld[r_ch] <= 1'b0;
            end
            if (i_cmd.commit) begin
                r_iode[r_ch] <= iode2;
                r_evld[r_ch] <= 1'b1;
                r_eidx       <= '0;
            end else if (i_cmd.out_item) begin
                r_eidx <= r_eidx + 5'd1;
            end
            if (i_cmd.out_item || i_cmd.out_drop) begin
                r_ovld <= 1'b1;
            end else if (!i_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovld;

endmodule
`default_nettype wire

@@ hdl/nav_ephemeris_assembler.sv @@
// top level of the navigation ephemeris assembler
`default_nettype none
// Per tracking channel, navigation words of subframes 1 to 3 are written into a
// word store (CHANNELS x 30 words); word index 9 of a subframe marks it held.
// When a commit completes all three subframes, the channel's 30 words are swept
// out of the store one per cycle through the single store read port and its read
// register, then the check state compares URA against max_range_accuracy and the
// health msb. A failed check or a clear command drops the channel and, if an
// ephemeris was valid, gives one dropped status beat (code 26). A consistent,
// new issue gives a run of 26 beats, one per cycle while the output is not
// stalled, carrying raw field integers; scale factors are left to software.
// Plain words are taken without stalling the input. A commit that starts a run
// holds the input through the sweep, the check, the run beats and the drain of
// the last beat; each output stall lengthens the hold. The input is stalled
// while a sweep, check, run, dropped beat or drain is in progress. The store
// has no reset; words never written read as anything.
module nav_ephemeris_assembler
    import nea_pkg::*;
#(
    parameter int CHANNELS = ChannelsDefault
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_cfg_we,
    input  wire logic [4:0]         i_cfg_wdata,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [0:0]         i_command,
    input  wire logic [3:0]         i_channel,
    input  wire logic [2:0]         i_subframe,
    input  wire logic [3:0]         i_word_index,
    input  wire logic [23:0]        i_nav_word,
    input  wire logic [5:0]         i_sat_prn,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [3:0]              o_out_channel,
    output logic [5:0]              o_out_prn,
    output logic [4:0]              o_item_code,
    output logic signed [32:0]      o_item_value,
    output logic                    o_last_item
);

    t_cmd cmd;
    t_sts sts;

    // sequencing: idle, sweep, check, run or drop beat, drain
    nea_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_cmd   (cmd)
    );

    // store, channel state, field extraction, output register
    nea_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_subframe    (i_subframe),
        .i_word_index  (i_word_index),
        .i_nav_word    (i_nav_word),
        .i_sat_prn     (i_sat_prn),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_out_channel (o_out_channel),
        .o_out_prn     (o_out_prn),
        .o_item_code   (o_item_code),
        .o_item_value  (o_item_value),
        .o_last_item   (o_last_item)
    );

endmodule
`default_nettype wire

@@ hdl/nea_checker.sv @@
// port checker of the navigation ephemeris assembler and its bind
`default_nettype none
module nea_checker
    import nea_pkg::*;
(
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               o_valid,
    input wire logic               i_stall,
    input wire logic [4:0]         o_item_code,
    input wire logic signed [32:0] o_item_value,
    input wire logic               o_last_item
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item_code) && $stable(o_item_value))
        else $error("stalled output beat changed");

    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_item_code == CodeDropped) |-> o_last_item && (o_item_value == 33'sd0))
        else $error("dropped beat malformed");

    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_item |-> (o_item_code == CodeLastRun) || (o_item_code == CodeDropped))
        else $error("last flag on wrong beat");

    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && !o_last_item |=> o_valid
        && (o_item_code == $past(o_item_code) + 5'd1))
        else $error("run beats not consecutive");

endmodule

bind nav_ephemeris_assembler nea_checker u_nea_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_item_code  (o_item_code),
    .o_item_value (o_item_value),
    .o_last_item  (o_last_item)
);
`default_nettype wire

@@ test/nav_ephemeris_assembler_tb.sv @@
// testbench of the navigation ephemeris assembler: directed and random beats, scoreboard checked
`timescale 1ns / 1ps
module nav_ephemeris_assembler_tb;
    import nea_pkg::*;

    localparam int NumCh = 12;
    localparam int HoldCycles = 300;
    localparam int SettleCycles = 64;

    typedef enum int {IssueGood, IssueRepeat, IssueMismatch, IssueBadHealth, IssueBadUra}
        t_issue_kind;

    // word fill patterns for a generated issue
    localparam int FillRandom = 0;
    localparam int FillZeros = 1;
    localparam int FillOnes = 2;

    // one result beat as the block reports it
    typedef struct packed {
        logic [3:0]  ch;
        logic [5:0]  prn;
        logic [4:0]  code;
        logic [32:0] value;
        logic        last;
    } t_eph_beat;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [4:0]         i_cfg_wdata = '0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic [0:0]         i_command = CmdWord;
    logic [3:0]         i_channel = '0;
    logic [2:0]         i_subframe = '0;
    logic [3:0]         i_word_index = '0;
    logic [23:0]        i_nav_word = '0;
    logic [5:0]         i_sat_prn = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic [3:0]         o_out_channel;
    logic [5:0]         o_out_prn;
    logic [4:0]         o_item_code;
    logic signed [32:0] o_item_value;
    logic               o_last_item;

    nav_ephemeris_assembler #(.CHANNELS(NumCh)) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_command     (i_command),
        .i_channel     (i_channel),
        .i_subframe    (i_subframe),
        .i_word_index  (i_word_index),
        .i_nav_word    (i_nav_word),
        .i_sat_prn     (i_sat_prn),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_channel (o_out_channel),
        .o_out_prn     (o_out_prn),
        .o_item_code   (o_item_code),
        .o_item_value  (o_item_value),
        .o_last_item   (o_last_item)
    );

    // predicted state of the block
    logic [23:0] nav_store [NumCh][3][10];
    logic [9:0]  word_seen [NumCh][3];     // store words written so far
    logic [2:0]  held_sf [NumCh];
    logic        eph_valid [NumCh];
    logic [7:0]  eph_iode [NumCh];
    logic [4:0]  ura_limit;
    logic [7:0]  issued_iode [NumCh];      // last consistent issue sent, for repeats

    t_eph_beat pending_beats[$];
    int        err_cnt = 0;
    int        beats_sent = 0;
    int        tx_idle_pct = 0;
    int        rx_stall_pct = 0;
    int        hold_req = 0;
    int        hold_left = 0;

    // clock, 10 ns period
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // run limit
    initial begin
        #5_000_000;
        $display("nav_ephemeris_assembler_tb: FAIL");
        $finish;
    end

    // receiver: random stall, or a long counted hold-off on request
    always @(negedge i_clk) begin
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_stall <= 1'b1;
            hold_left--;
        end else begin
            i_stall <= (rx_stall_pct > 0) && ($urandom_range(0, 99) < rx_stall_pct);
        end
    end

    // scoreboard: every output beat against the oldest prediction
    always @(posedge i_clk) begin
        t_eph_beat want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                err_cnt++;
                if (err_cnt <= 10)
                    $display("unexpected beat: ch %0d prn %0d code %0d value %0h last %0b",
                             o_out_channel, o_out_prn, o_item_code, o_item_value, o_last_item);
            end else begin
                want = pending_beats.pop_front();
                if (want.ch !== o_out_channel || want.prn !== o_out_prn ||
                    want.code !== o_item_code || want.value !== o_item_value ||
                    want.last !== o_last_item) begin
                    err_cnt++;
                    if (err_cnt <= 10) begin
                        $write("mismatch: exp ch %0d prn %0d code %0d value %0h last %0b,",
                               want.ch, want.prn, want.code, want.value, want.last);
                        $display(" got ch %0d prn %0d code %0d value %0h last %0b",
                                 o_out_channel, o_out_prn, o_item_code, o_item_value,
                                 o_last_item);
                    end
                end
            end
        end
    end

    function automatic logic [32:0] sext(input logic [31:0] v, input int bits);
        logic [32:0] r;
        for (int i = 0; i < 33; i++)
            r[i] = (i < bits) ? v[i] : v[bits - 1];
        return r;
    endfunction

    task automatic push_beat(input logic [3:0] ch, input logic [5:0] prn,
                             input logic [4:0] code, input logic [32:0] value,
                             input logic last);
        t_eph_beat b;
        b.ch = ch;
        b.prn = prn;
        b.code = code;
        b.value = value;
        b.last = last;
        pending_beats.push_back(b);
    endtask

    // clear of a channel; status beat only if an ephemeris was held
    task automatic drop_channel(input int ch, input logic [5:0] prn);
        logic was;
        was = eph_valid[ch];
        eph_valid[ch] = 1'b0;
        held_sf[ch] = '0;
        if (was)
            push_beat(4'(ch), prn, CodeDropped, '0, 1'b1);
    endtask

    // all three subframes held: check, then predict the run of raw fields
    task automatic assemble_ephemeris(input int ch, input logic [5:0] prn);
        logic [23:0] s1 [10];
        logic [23:0] s2 [10];
        logic [23:0] s3 [10];
        logic [32:0] run [RunLen];
        logic [9:0]  iodc;
        logic [3:0]  ura;
        logic [5:0]  health;
        logic [7:0]  iode2;
        logic [7:0]  iode3;
        s1 = nav_store[ch][0];
        s2 = nav_store[ch][1];
        s3 = nav_store[ch][2];
        iodc = {s1[2][1:0], s1[7][23:16]};
        ura = s1[2][11:8];
        health = s1[2][7:2];
        iode2 = s2[2][23:16];
        iode3 = s3[9][23:16];
        if (!({1'b0, ura} < ura_limit) || health[5]) begin
            drop_channel(ch, prn);
            return;
        end
        // inconsistent or unchanged issue: silently kept
        if (iodc[7:0] != iode2 || iode2 != iode3)
            return;
        if (eph_valid[ch] && eph_iode[ch] == iode2)
            return;
        run[0]  = 33'(s1[2][23:14]);
        run[1]  = 33'(ura);
        run[2]  = 33'(health);
        run[3]  = 33'(iodc);
        run[4]  = 33'(iode2);
        run[5]  = 33'(s1[7][15:0]);
        run[6]  = sext(s1[6][7:0], 8);
        run[7]  = sext(s1[8][23:16], 8);
        run[8]  = sext(s1[8][15:0], 16);
        run[9]  = sext(s1[9][23:2], 22);
        run[10] = sext(s2[2][15:0], 16);
        run[11] = sext(s2[3][23:8], 16);
        run[12] = sext({s2[3][7:0], s2[4]}, 32);
        run[13] = sext(s2[5][23:8], 16);
        run[14] = 33'({s2[5][7:0], s2[6]});     // eccentricity stays unsigned
        run[15] = sext(s2[7][23:8], 16);
        run[16] = 33'({s2[7][7:0], s2[8]});
        run[17] = 33'(s2[9][23:8]);
        run[18] = sext(s3[2][23:8], 16);
        run[19] = sext({s3[2][7:0], s3[3]}, 32);
        run[20] = sext(s3[4][23:8], 16);
        run[21] = sext({s3[4][7:0], s3[5]}, 32);
        run[22] = sext(s3[6][23:8], 16);
        run[23] = sext({s3[6][7:0], s3[7]}, 32);
        run[24] = sext(s3[8], 24);
        run[25] = sext(s3[9][15:2], 14);
        eph_iode[ch] = iode2;
        eph_valid[ch] = 1'b1;
        for (int i = 0; i < RunLen; i++)
            push_beat(4'(ch), prn, 5'(i), run[i], i == RunLen - 1);
    endtask

    // effect of one accepted input beat
    task automatic apply_beat(input logic [0:0] cmd, input logic [3:0] ch,
                              input logic [2:0] sf, input logic [3:0] wi,
                              input logic [23:0] w, input logic [5:0] prn);
        if (ch >= NumCh)
            return;
        if (cmd == CmdClear) begin
            drop_channel(ch, prn);
            return;
        end
        if (sf < 1 || sf > SfKept || wi >= SfWords)
            return;
        nav_store[ch][sf - 1][wi] = w;
        word_seen[ch][sf - 1][wi] = 1'b1;
        if (wi != SfWords - 1)
            return;
        held_sf[ch] = held_sf[ch] | 3'(1 << (sf - 1));
        if (held_sf[ch] != 3'b111)
            return;
        assemble_ephemeris(ch, prn);
    endtask

    task automatic send_beat(input logic [0:0] cmd, input logic [3:0] ch,
                             input logic [2:0] sf, input logic [3:0] wi,
                             input logic [23:0] w, input logic [5:0] prn);
        @(negedge i_clk);
        while (tx_idle_pct > 0 && $urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_channel <= ch;
        i_subframe <= sf;
        i_word_index <= wi;
        i_nav_word <= w;
        i_sat_prn <= prn;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        apply_beat(cmd, ch, sf, wi, w, prn);
        beats_sent++;
    endtask

    // any field values; a commit is only let through when store words 2 to 8 of its subframe exist
    task automatic send_noise();
        logic [0:0] cmd;
        logic [3:0] ch;
        logic [2:0] sf;
        logic [3:0] wi;
        cmd = ($urandom_range(0, 6) == 0) ? CmdClear : CmdWord;
        ch = 4'($urandom_range(0, 15));
        sf = 3'($urandom_range(0, 7));
        wi = 4'($urandom_range(0, 15));
        if (cmd == CmdWord && ch < NumCh && sf >= 1 && sf <= SfKept && wi == SfWords - 1 &&
            word_seen[ch][sf - 1][8:2] != 7'h7f)
            wi = 4'($urandom_range(0, 8));
        send_beat(cmd, ch, sf, wi, 24'($urandom), 6'($urandom_range(0, 63)));
    endtask

    task automatic send_subframe(input logic [3:0] ch, input logic [5:0] prn,
                                 input int sf, input logic [23:0] words [10],
                                 input bit mix);
        for (int wi = 0; wi < SfWords; wi++) begin
            if (mix && $urandom_range(0, 9) == 0)
                send_noise();
            send_beat(CmdWord, ch, 3'(sf), 4'(wi), words[wi], prn);
        end
    endtask

    // three well-formed subframes carrying one ephemeris issue
    task automatic send_issue(input logic [3:0] ch, input t_issue_kind kind,
                              input int fill, input bit mix);
        logic [23:0] w [3][10];
        logic [7:0]  iode;
        logic [3:0]  ura;
        logic [5:0]  health;
        logic [5:0]  prn;
        logic [7:0]  flip;
        int          top;
        int          pick;
        prn = 6'($urandom_range(0, 63));
        iode = (kind == IssueRepeat) ? issued_iode[ch] : 8'($urandom_range(0, 255));
        top = (ura_limit > 16) ? 16 : ura_limit;
        if (kind == IssueBadUra)
            ura = 4'($urandom_range((top > 15) ? 15 : top, 15));
        else
            ura = (top == 0) ? 4'd0 : 4'($urandom_range(0, top - 1));
        health = 6'($urandom_range(0, 31));
        if (kind == IssueBadHealth)
            health[5] = 1'b1;
        for (int s = 0; s < 3; s++)
            for (int k = 0; k < 10; k++)
                w[s][k] = (fill == FillZeros) ? 24'h0 :
                          (fill == FillOnes) ? 24'hffffff : 24'($urandom);
        w[0][2] = {w[0][2][23:12], ura, health, w[0][2][1:0]};
        w[0][7][23:16] = iode;
        w[1][2][23:16] = iode;
        w[2][9][23:16] = iode;
        if (kind == IssueMismatch) begin
            pick = $urandom_range(0, 2);
            flip = 8'($urandom_range(1, 255));
            if (pick == 0)
                w[0][7][23:16] ^= flip;
            else if (pick == 1)
                w[1][2][23:16] ^= flip;
            else
                w[2][9][23:16] ^= flip;
        end else begin
            issued_iode[ch] = iode;
        end
        for (int s = 0; s < 3; s++)
            send_subframe(ch, prn, s + 1, w[s], mix);
    endtask

    // wait until every predicted beat is out, then let the block settle
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge i_clk);
        repeat (SettleCycles) @(posedge i_clk);
    endtask

    task automatic write_ura_limit(input logic [4:0] v);
        drain();
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        ura_limit = v;
    endtask

    // words that must be ignored: bad channel, subframe, word index, empty clears
    task automatic test_ignored_words();
        send_beat(CmdWord, 4'd15, 3'd1, 4'd9, 24'hffffff, 6'd63);
        send_beat(CmdWord, 4'd12, 3'd2, 4'd0, 24'h0, 6'd0);
        send_beat(CmdWord, 4'd0, 3'd0, 4'd9, 24'hffffff, 6'd1);
        send_beat(CmdWord, 4'd1, 3'd4, 4'd9, 24'h123456, 6'd2);
        send_beat(CmdWord, 4'd2, 3'd5, 4'd9, 24'hffffff, 6'd3);
        send_beat(CmdWord, 4'd3, 3'd6, 4'd3, 24'h000001, 6'd4);
        send_beat(CmdWord, 4'd4, 3'd7, 4'd9, 24'h800000, 6'd5);
        send_beat(CmdWord, 4'd5, 3'd1, 4'd10, 24'hffffff, 6'd6);
        send_beat(CmdWord, 4'd11, 3'd3, 4'd15, 24'hffffff, 6'd7);
        send_beat(CmdClear, 4'd0, 3'd0, 4'd0, 24'h0, 6'd8);
        send_beat(CmdClear, 4'd14, 3'd7, 4'd15, 24'hffffff, 6'd62);
        drain();
    endtask

    // accept, repeat, clear, health failure, field extremes
    task automatic test_ephemeris_runs();
        send_issue(4'd0, IssueGood, FillOnes, 1'b0);
        send_issue(4'd0, IssueRepeat, FillRandom, 1'b0);
        send_beat(CmdClear, 4'd0, 3'd1, 4'd0, 24'h0, 6'd9);
        send_beat(CmdClear, 4'd0, 3'd1, 4'd0, 24'h0, 6'd9);
        send_issue(4'd11, IssueGood, FillZeros, 1'b0);
        send_issue(4'd11, IssueBadHealth, FillRandom, 1'b0);
        drain();
    endtask

    // limit register at its extremes and a few values between
    task automatic test_ura_limit();
        write_ura_limit(5'd0);
        send_issue(4'd3, IssueGood, FillRandom, 1'b0);
        write_ura_limit(5'd16);
        send_issue(4'd3, IssueGood, FillRandom, 1'b0);
        write_ura_limit(5'd31);
        send_issue(4'd7, IssueGood, FillRandom, 1'b0);
        write_ura_limit(5'd1);
        send_issue(4'd7, IssueBadUra, FillRandom, 1'b0);
        write_ura_limit(UraLimitReset);
    endtask

    // receiver holds off long while words keep coming, so the input backs up
    task automatic test_output_hold();
        hold_req = HoldCycles;
        send_issue(4'd6, IssueGood, FillRandom, 1'b0);
        for (int i = 0; i < 6; i++)
            send_noise();
        drain();
    endtask

    task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
        int first;
        int r;
        int k;
        int upto;
        logic [3:0] ch;
        t_issue_kind kind;
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        first = beats_sent;
        while (beats_sent - first < count) begin
            r = $urandom_range(0, 19);
            ch = 4'($urandom_range(0, NumCh - 1));
            if (r < 2) begin
                send_noise();
            end else if (r < 3) begin
                send_beat(CmdClear, 4'($urandom_range(0, 15)), 3'($urandom_range(0, 7)),
                          4'($urandom_range(0, 15)), 24'($urandom),
                          6'($urandom_range(0, 63)));
            end else if (r < 4) begin
                // broken subframe, never committed
                upto = $urandom_range(0, 8);
                for (int wi = 0; wi <= upto; wi++)
                    send_beat(CmdWord, ch, 3'($urandom_range(1, 3)), 4'(wi),
                              24'($urandom), 6'($urandom_range(0, 63)));
            end else begin
                k = $urandom_range(0, 9);
                kind = (k == 5) ? IssueRepeat : (k == 6) ? IssueMismatch :
                       (k == 7) ? IssueBadHealth : (k == 8) ? IssueBadUra : IssueGood;
                send_issue(ch, kind, ($urandom_range(0, 7) == 0) ? FillOnes : FillRandom,
                           1'b1);
            end
        end
        drain();
    endtask

    initial begin
        for (int c = 0; c < NumCh; c++) begin
            held_sf[c] = '0;
            eph_valid[c] = 1'b0;
            eph_iode[c] = '0;
            issued_iode[c] = '0;
            for (int s = 0; s < 3; s++)
                word_seen[c][s] = '0;
        end
        ura_limit = UraLimitReset;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_ignored_words();
        test_ephemeris_runs();
        test_ura_limit();
        test_output_hold();
        test_random_traffic(29, 86, 30);
        test_random_traffic(86, 29, 30);
        test_random_traffic(0, 0, 30);

        if (err_cnt == 0 && pending_beats.size() == 0)
            $display("nav_ephemeris_assembler_tb: PASS");
        else
            $display("nav_ephemeris_assembler_tb: FAIL");
        $finish;
    end

endmodule
